/* rtl/core/sgf_pkg.sv */
// Package for the Sobel gradient filter: sizes, register indexes, reset values
// and the control tag handed from the front stage to the kernel stage.
// No dependencies.
package sgf_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_PIXEL_BITS = 8;

  localparam int MAX_HEIGHT      = 4096;
  localparam int ROW_BITS        = 12;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 13;

  localparam int GRAD_BITS     = 11;
  localparam int GRAD_MIN      = -1024;
  localparam int GRAD_MAX      = 1023;
  localparam int OUT_DATA_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRADIENT_DIRECTION = 2'd2;

  localparam logic [WIDTH_REG_BITS-1:0]  RESET_IMAGE_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_BITS-1:0] RESET_IMAGE_HEIGHT = 13'd480;

  localparam logic DIR_HORIZONTAL = 1'b0;
  localparam logic DIR_VERTICAL   = 1'b1;

  typedef struct packed {
    logic emit;
    logic last;
  } sgf_tag_t;

endpackage

/* rtl/core/sobel_gradient_filter.sv */
// Top level of the streaming 3x3 Sobel gradient filter: counters, row store,
// a chain of two window column cells and the kernel output stage.
// Depends on sgf_pkg, sgf_row_store, sgf_column_cell, sgf_kernel.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: pixel
//   m_*      out  m_tvalid/m_tready  m_tdata: gradient; m_tlast: frame_last
//   cfg_*    in   cfg_wr_en          cfg_index, cfg_data
//
// One pixel per clock while the output is not stalled; after its pixel transfer a result
// passes the pixel register (row store read beside it), then the output register.
// The single row store port pair sets the rate: one read and one write a cycle.
// Reset clears counters, window and valid flags; the row store is not cleared.
// A stalled output holds the window stage, which in turn holds s_tready low.
module sobel_gradient_filter #(
  parameter int MAX_WIDTH  = sgf_pkg::DEFAULT_MAX_WIDTH,
  parameter int PIXEL_BITS = sgf_pkg::DEFAULT_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [8*((PIXEL_BITS+7)/8)-1:0]     s_tdata,   // [PIXEL_BITS-1:0] pixel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sgf_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // [10:0] gradient
  output logic                                m_tlast,   // frame_last
  input  logic                                cfg_wr_en,
  input  logic [sgf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sgf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  import sgf_pkg::*;

  localparam int COL_BITS = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCMP     = (COL_BITS + 1 > WIDTH_REG_BITS) ? COL_BITS + 1 : WIDTH_REG_BITS;
  localparam int HCMP     = HEIGHT_REG_BITS;

  logic [WIDTH_REG_BITS-1:0]  image_width;
  logic [HEIGHT_REG_BITS-1:0] image_height;
  logic                       gradient_direction;

  logic [WCMP-1:0]     width_eff;
  logic [HCMP-1:0]     height_eff;
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic [COL_BITS-1:0] col_next;
  logic [ROW_BITS-1:0] row_next;
  logic [WCMP-1:0]     col_plus;
  logic [HCMP-1:0]     row_plus;
  sgf_tag_t            tag_next;

  logic                  in_acc;
  logic                  s1_valid;
  logic                  s1_go;
  logic [COL_BITS-1:0]   s1_col;
  logic [PIXEL_BITS-1:0] s1_pixel;
  sgf_tag_t              s1_tag;
  logic [2*PIXEL_BITS-1:0] rd_data;
  logic [PIXEL_BITS-1:0] cur_top;
  logic [PIXEL_BITS-1:0] cur_mid;
  logic                  kernel_ready;

  logic [PIXEL_BITS-1:0] c1_top, c1_mid, c1_bot;
  logic [PIXEL_BITS-1:0] c0_top, c0_mid, c0_bot;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= RESET_IMAGE_WIDTH;
      image_height       <= RESET_IMAGE_HEIGHT;
      gradient_direction <= DIR_HORIZONTAL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:        image_width        <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_IMAGE_HEIGHT:       image_height       <= cfg_data[HEIGHT_REG_BITS-1:0];
        REG_GRADIENT_DIRECTION: gradient_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (WCMP'(image_width) < WCMP'(3)) begin
      width_eff = WCMP'(3);
    end else if (WCMP'(image_width) > WCMP'(MAX_WIDTH)) begin
      width_eff = WCMP'(MAX_WIDTH);
    end else begin
      width_eff = WCMP'(image_width);
    end
    if (image_height < HCMP'(3)) begin
      height_eff = HCMP'(3);
    end else if (image_height > HCMP'(MAX_HEIGHT)) begin
      height_eff = HCMP'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  // position counters and result tag
  always_comb begin
    col_plus = WCMP'(col) + WCMP'(1);
    row_plus = HCMP'(row) + HCMP'(1);
    if (col_plus >= width_eff) begin
      col_next = '0;
      row_next = (row_plus >= height_eff) ? '0 : row_plus[ROW_BITS-1:0];
    end else begin
      col_next = col_plus[COL_BITS-1:0];
      row_next = row;
    end
    tag_next.emit = (row >= ROW_BITS'(2)) && (col >= COL_BITS'(2));
    tag_next.last = (row_plus == height_eff) && (col_plus == width_eff);
  end

  assign s1_go    = s1_valid && kernel_ready;
  assign s_tready = !s1_valid || s1_go;
  assign in_acc   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        col <= col_next;
        row <= row_next;
      end
      if (s_tready) begin
        s1_valid <= in_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col   <= col;
      s1_pixel <= s_tdata[PIXEL_BITS-1:0];
      s1_tag   <= tag_next;
    end
  end

  assign cur_top = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign cur_mid = rd_data[PIXEL_BITS-1:0];

  sgf_row_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2*PIXEL_BITS)
  ) u_row_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data ({cur_mid, s1_pixel})
  );

  sgf_column_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_center (
    .clk    (clk),
    .rst    (rst),
    .shift  (s1_go),
    .top_in (cur_top),
    .mid_in (cur_mid),
    .bot_in (s1_pixel),
    .top    (c1_top),
    .mid    (c1_mid),
    .bot    (c1_bot)
  );

  sgf_column_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_left (
    .clk    (clk),
    .rst    (rst),
    .shift  (s1_go),
    .top_in (c1_top),
    .mid_in (c1_mid),
    .bot_in (c1_bot),
    .top    (c0_top),
    .mid    (c0_mid),
    .bot    (c0_bot)
  );

  sgf_kernel #(.PIXEL_BITS(PIXEL_BITS)) u_kernel (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go),
    .tag       (s1_tag),
    .direction (gradient_direction),
    .tl        (c0_top),
    .ml        (c0_mid),
    .bl        (c0_bot),
    .tc        (c1_top),
    .bc        (c1_bot),
    .tr        (cur_top),
    .mr        (cur_mid),
    .br        (s1_pixel),
    .ready     (kernel_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> s1_valid)
    else $error("accepted pixel did not reach the window stage");

  a_emit_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_tag.emit) |=> m_tvalid)
    else $error("interior result lost before the output register");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("input stalled without a full pipeline");

  a_skip_border: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !s1_tag.emit && m_tvalid && m_tready) |=> !m_tvalid)
    else $error("border pixel produced a result");

endmodule

/* rtl/core/sgf_row_store.sv */
// Two-row line store: one write port and one registered read port.
// Each entry packs the row two back (upper half) and the row one back (lower half).
// Depends on nothing.
module sgf_row_store #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_BITS-1:0]     rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_BITS-1:0]     wr_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/sgf_column_cell.sv */
// One column cell of the 3x3 window: holds top, middle and bottom pixels and
// passes them on to its neighbor on each shift. Depends on nothing.
module sgf_column_cell #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic [PIXEL_BITS-1:0] top_in,
  input  logic [PIXEL_BITS-1:0] mid_in,
  input  logic [PIXEL_BITS-1:0] bot_in,
  output logic [PIXEL_BITS-1:0] top,
  output logic [PIXEL_BITS-1:0] mid,
  output logic [PIXEL_BITS-1:0] bot
);

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      mid <= '0;
      bot <= '0;
    end else if (shift) begin
      top <= top_in;
      mid <= mid_in;
      bot <= bot_in;
    end
  end

endmodule

/* rtl/core/sgf_kernel.sv */
// Sobel kernel with saturation and the output register of the filter.
// Depends on sgf_pkg.
module sgf_kernel #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  sgf_pkg::sgf_tag_t                    tag,
  input  logic                                 direction,
  input  logic [PIXEL_BITS-1:0]                tl,
  input  logic [PIXEL_BITS-1:0]                ml,
  input  logic [PIXEL_BITS-1:0]                bl,
  input  logic [PIXEL_BITS-1:0]                tc,
  input  logic [PIXEL_BITS-1:0]                bc,
  input  logic [PIXEL_BITS-1:0]                tr,
  input  logic [PIXEL_BITS-1:0]                mr,
  input  logic [PIXEL_BITS-1:0]                br,
  output logic                                 ready,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sgf_pkg::OUT_DATA_BITS-1:0]    m_tdata,  // [10:0] gradient
  output logic                                 m_tlast   // frame_last
);

  import sgf_pkg::*;

  localparam int GX = (PIXEL_BITS + 4 > GRAD_BITS + 1) ? PIXEL_BITS + 4 : GRAD_BITS + 1;
  localparam logic signed [GX-1:0] SAT_MIN = GX'(GRAD_MIN);
  localparam logic signed [GX-1:0] SAT_MAX = GX'(GRAD_MAX);

  logic signed [GX-1:0]    pos;
  logic signed [GX-1:0]    neg;
  logic signed [GX-1:0]    diff;
  logic [GRAD_BITS-1:0]    grad_next;
  logic [GRAD_BITS-1:0]    gradient;

  always_comb begin
    if (direction == DIR_HORIZONTAL) begin
      pos = GX'(tr) + (GX'(mr) <<< 1) + GX'(br);
      neg = GX'(tl) + (GX'(ml) <<< 1) + GX'(bl);
    end else begin
      pos = GX'(bl) + (GX'(bc) <<< 1) + GX'(br);
      neg = GX'(tl) + (GX'(tc) <<< 1) + GX'(tr);
    end
    diff = pos - neg;
    if (diff < SAT_MIN) begin
      grad_next = SAT_MIN[GRAD_BITS-1:0];
    end else if (diff > SAT_MAX) begin
      grad_next = SAT_MAX[GRAD_BITS-1:0];
    end else begin
      grad_next = diff[GRAD_BITS-1:0];
    end
  end

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= load && tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      gradient <= grad_next;
      m_tlast  <= tag.last;
    end
  end

  assign m_tdata = {{(OUT_DATA_BITS - GRAD_BITS){1'b0}}, gradient};

endmodule

/* sim/sobel_gradient_filter_tb.sv */
// Self-checking testbench for sobel_gradient_filter: drives pixel transfers,
// predicts each gradient and compares it with the output stream.
// Depends on sgf_pkg and the sobel_gradient_filter RTL.
module sobel_gradient_filter_tb;
  import sgf_pkg::*;

  localparam int PIX_BITS       = DEFAULT_PIXEL_BITS;
  localparam int ROW_SLOTS      = DEFAULT_MAX_WIDTH;
  localparam int PIPE_SLACK     = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PIXELS  = 320;

  typedef bit [PIX_BITS-1:0] pixel_t;

  typedef struct packed {
    logic signed [GRAD_BITS-1:0] gradient;
    logic                        frame_last;
  } gradient_result_t;

  typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_NEAR} pixel_style_t;
  typedef enum {RX_OPEN, RX_CHOPPY, RX_BURSTY} rx_mode_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [PIX_BITS-1:0]         s_tdata   = '0;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [OUT_DATA_BITS-1:0]    m_tdata;
  logic                        m_tlast;
  logic                        cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]    cfg_data  = '0;

  sobel_gradient_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [WIDTH_REG_BITS-1:0]  width_reg     = RESET_IMAGE_WIDTH;
  logic [HEIGHT_REG_BITS-1:0] height_reg    = RESET_IMAGE_HEIGHT;
  logic                       direction_reg = DIR_HORIZONTAL;
  pixel_t                     older_row [ROW_SLOTS];
  pixel_t                     newer_row [ROW_SLOTS];
  pixel_t                     window [6];
  int unsigned                col_count = 0;
  int unsigned                row_count = 0;

  gradient_result_t expected_results [$];
  int               mismatch_count = 0;
  int               burst_left     = 0;
  bit               sender_steady  = 1'b0;

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > ROW_SLOTS) return ROW_SLOTS;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, in_row, rows_after;
    w = active_width();
    h = active_height();
    in_row = (col_count + 1 >= w) ? 1 : w - col_count;
    rows_after = (row_count + 1 >= h) ? 0 : h - row_count - 1;
    return in_row + rows_after * w;
  endfunction

  function automatic void filter_pixel(input pixel_t px);
    int unsigned      w, h, c, r;
    int               top, mid, bot, g;
    gradient_result_t res;
    w = active_width();
    h = active_height();
    c = col_count;
    r = row_count;
    top = 0;
    mid = 0;
    bot = px;
    if (c < ROW_SLOTS) begin
      top = older_row[c];
      mid = newer_row[c];
      older_row[c] = newer_row[c];
      newer_row[c] = px;
    end
    if (r >= 2 && c >= 2) begin
      if (direction_reg == DIR_HORIZONTAL) begin
        g = (top + 2 * mid + bot) - (window[0] + 2 * window[1] + window[2]);
      end else begin
        g = (window[2] + 2 * window[5] + bot) - (window[0] + 2 * window[3] + top);
      end
      if (g < GRAD_MIN) g = GRAD_MIN;
      if (g > GRAD_MAX) g = GRAD_MAX;
      res.gradient   = GRAD_BITS'(g);
      res.frame_last = (r == h - 1) && (c == w - 1);
      expected_results.push_back(res);
    end
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = pixel_t'(top);
    window[4] = pixel_t'(mid);
    window[5] = px;
    if (c + 1 >= w) begin
      col_count = 0;
      row_count = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_count = c + 1;
    end
  endfunction

  task automatic send_pixel(input pixel_t px);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 32);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = px;
    do @(posedge clk); while (!s_tready);
    if (burst_left != 0) burst_left--;
    filter_pixel(px);
  endtask

  task automatic send_run(input int count, input pixel_style_t style);
    int base, px;
    base = $urandom_range(0, 255);
    sender_steady = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      case (style)
        PIX_EXTREME: px = $urandom_range(0, 1) ? 255 : 0;
        PIX_NEAR: begin
          px = base + int'($urandom_range(0, 16)) - 8;
          if (px < 0) px = 0;
          if (px > 255) px = 255;
        end
        default: px = $urandom_range(0, 255);
      endcase
      send_pixel(pixel_t'(px));
    end
  endtask

  // drop valid, let every expected transfer arrive, then let the pipeline empty
  task automatic wait_for_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_BITS'(value);
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:        width_reg     = WIDTH_REG_BITS'(value);
      REG_IMAGE_HEIGHT:       height_reg    = HEIGHT_REG_BITS'(value);
      REG_GRADIENT_DIRECTION: direction_reg = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic test_reset_geometry();
    // start a row at the reset width, then narrow it past the current column
    send_run(10, PIX_RANDOM);
    wait_for_drain();
    write_reg(REG_IMAGE_WIDTH, 5);
    send_run(1 + 5 * 5, PIX_RANDOM);
    wait_for_drain();
    // cut the frame short so that the next row closes it
    write_reg(REG_IMAGE_HEIGHT, 4);
    send_run(5, PIX_NEAR);
    wait_for_drain();
  endtask

  task automatic test_directed_extremes();
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 2);
    write_reg(REG_GRADIENT_DIRECTION, DIR_HORIZONTAL);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'd255 : 8'd0);
    wait_for_drain();
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(REG_GRADIENT_DIRECTION, DIR_VERTICAL);
    for (int i = 0; i < 9; i++) send_pixel((i < 3) ? 8'd255 : ((i < 6) ? 8'd128 : 8'd0));
    wait_for_drain();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_GRADIENT_DIRECTION, DIR_HORIZONTAL);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'd255 : ((i % 3 == 1) ? 8'd77 : 8'd0));
    wait_for_drain();
  endtask

  task automatic test_largest_geometry();
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 8191);
    write_reg(REG_GRADIENT_DIRECTION, DIR_VERTICAL);
    send_run(20, PIX_RANDOM);
    wait_for_drain();
    write_reg(REG_IMAGE_WIDTH, 4);
    send_run(1 + 6 * 4, PIX_EXTREME);
    wait_for_drain();
    write_reg(REG_IMAGE_HEIGHT, 3);
    send_run(4, PIX_RANDOM);
    wait_for_drain();
  endtask

  task automatic test_random_frames();
    int sent, left, n;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if (col_count == 0 && row_count == 0) begin
        wait_for_drain();
        if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, $urandom_range(0, 14));
        if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 8));
        if ($urandom_range(0, 3) != 0) begin
          write_reg(REG_GRADIENT_DIRECTION, $urandom_range(0, 1));
        end
      end else if ($urandom_range(0, 3) == 0) begin
        wait_for_drain();
        case ($urandom_range(0, 2))
          0: write_reg(REG_GRADIENT_DIRECTION, !direction_reg);
          // shrink only: the stored rows must cover every column still read
          1: write_reg(REG_IMAGE_WIDTH, $urandom_range(0, active_width()));
          default: write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 9));
        endcase
      end
      left = pixels_to_frame_end();
      n = $urandom_range(0, 1) ? left : $urandom_range(1, left);
      send_run(n, pixel_style_t'($urandom_range(0, 2)));
      sent += n;
    end
    wait_for_drain();
  endtask

  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_cycle = 0;
  int       rx_hold  = 0;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
    if (rx_hold != 0) begin
      m_tready = 1'b0;
      rx_hold--;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_tready = 1'b1;
        RX_CHOPPY: m_tready = ($urandom_range(0, 2) != 0);
        default: begin
          m_tready = 1'b1;
          if ($urandom_range(0, 9) == 0) rx_hold = $urandom_range(2, 16);
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_gradient
    gradient_result_t            want;
    logic signed [GRAD_BITS-1:0] got;
    got = m_tdata[GRAD_BITS-1:0];
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("gradient: no transfer expected, got %0d", got);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want.gradient) begin
          $error("gradient: expected %0d, got %0d", want.gradient, got);
          mismatch_count++;
        end
        if (m_tlast !== want.frame_last) begin
          $error("frame_last: expected %0b, got %0b", want.frame_last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL sobel_gradient_filter");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_geometry();
    test_directed_extremes();
    test_largest_geometry();
    test_random_frames();
    if (mismatch_count == 0) begin
      $display("PASS sobel_gradient_filter");
    end else begin
      $display("FAIL sobel_gradient_filter");
    end
    $finish;
  end

endmodule
